// ===== hw/rtl/modular_sequence_unwrap_unit_defines.svh =====
// Assertion macros for the modular sequence unwrap unit.
// Included by the RTL files that carry concurrent assertions.
// Compiled out when SYNTH is defined.
`ifndef MODULAR_SEQUENCE_UNWRAP_UNIT_DEFINES_SVH
`define MODULAR_SEQUENCE_UNWRAP_UNIT_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication.
`define MSU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msu assertion failed");

// Next-cycle implication.
`define MSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msu assertion failed");

`else

`define MSU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/msu_pkg.sv =====
// Package for the modular sequence unwrap unit.
// Field widths, register map and parameter defaults; no dependencies.
package msu_pkg;

    localparam int MOD_W    = 13;
    localparam int LIFTED_W = 26;
    localparam int LIFT_W   = 15;
    localparam int INCR_W   = 14;

    localparam logic [MOD_W-1:0] MOD_RESET = 13'd4096;

    localparam int DEF_SAMPLE_BITS = 12;
    localparam int DEF_MAX_MODULUS = 4096;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_MODULUS = 1'b0;

endpackage

// ===== hw/rtl/modular_sequence_unwrap_unit.sv =====
// Modular sequence unwrap unit: lifts residues mod q to a continuous sequence.
// Depends on msu_pkg and modular_sequence_unwrap_unit_defines.svh.
//
// Samples arrive in runs of q (the modulus register). The first sample of a run
// passes unchanged with lift 0; each later sample is lifted by k*q so that it
// lands nearest the previous lifted value. One sample is in work at a time. The
// first sample of a run goes straight from accept to the output state; every other
// sample passes through the restoring divider, which produces one quotient bit per
// cycle, then a correction step, a comparison of the three candidate lifts, and the
// output state.
// The result sits in an output register, so a stalled result does not block the
// next sample's work until that sample is ready to be written out. Writing the
// modulus register restarts the run.
`include "modular_sequence_unwrap_unit_defines.svh"

module modular_sequence_unwrap_unit
    import msu_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int MAX_MODULUS = DEF_MAX_MODULUS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready,

    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [SAMPLE_BITS-1:0]       i_sample,

    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [LIFTED_W-1:0]   o_lifted_value,
    output logic signed [LIFT_W-1:0]     o_lift,
    output logic signed [INCR_W-1:0]     o_increment,
    output logic                         o_last
);

    localparam int VAL_W  = ((SAMPLE_BITS > 2*MOD_W-1) ? SAMPLE_BITS : 2*MOD_W-1) + 2;
    localparam int NUM_W  = VAL_W + 1;
    localparam int QUO_W  = ((SAMPLE_BITS > MOD_W-1) ? SAMPLE_BITS : MOD_W-1) + 2;
    localparam int R_W    = MOD_W + QUO_W;
    localparam int KW     = QUO_W + 2;
    localparam int DB_W   = MOD_W + 3;
    localparam int CNT_W  = $clog2(QUO_W);

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_FIX, S_CAND, S_DONE} t_state;

    t_state                    r_state;
    logic [MOD_W-1:0]          r_modulus;
    logic signed [VAL_W-1:0]   r_prev_val;
    logic signed [KW-1:0]      r_prev_k;
    logic [MOD_W-1:0]          r_pos;
    logic                      r_first;
    logic                      r_neg;
    logic [R_W-1:0]            r_rem;
    logic [R_W-1:0]            r_dq;
    logic [QUO_W-1:0]          r_quo;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [KW-1:0]      r_k0;
    logic signed [DB_W-1:0]    r_dbase;
    logic [1:0]                r_ci;
    logic signed [KW-1:0]      r_best_k;
    logic [DB_W-1:0]           r_best_d;
    logic signed [VAL_W-1:0]   r_best_val;
    logic                      r_out_valid;
    logic signed [LIFTED_W-1:0] r_lifted;
    logic signed [LIFT_W-1:0]  r_lift;
    logic signed [INCR_W-1:0]  r_incr;
    logic                      r_last;

    logic [MOD_W-1:0]          q_eff;
    logic signed [MOD_W:0]     q_s;
    logic signed [MOD_W:0]     half_s;
    logic                      in_accept;
    logic                      cfg_wr;
    logic                      out_free;
    logic                      is_last;
    logic signed [NUM_W-1:0]   num;
    logic [NUM_W-1:0]          num_mag;
    logic                      div_ge;
    logic signed [KW-1:0]      quo_s;
    logic signed [DB_W-1:0]    rem_s;
    logic signed [DB_W-1:0]    off_s;
    logic signed [KW-1:0]      kdel;
    logic signed [DB_W-1:0]    cand_x;
    logic [DB_W-1:0]           cand_d;
    logic signed [KW-1:0]      cand_k;
    logic [KW-1:0]             cand_kmag;
    logic [KW-1:0]             best_kmag;
    logic                      cand_take;
    logic signed [VAL_W-1:0]   cand_val;

    always_comb begin
        if (r_modulus == '0) begin
            q_eff = MOD_W'(1);
        end else if (32'(r_modulus) > MAX_MODULUS) begin
            q_eff = MOD_W'(MAX_MODULUS);
        end else begin
            q_eff = r_modulus;
        end
    end

    assign q_s    = $signed({1'b0, q_eff});
    assign half_s = $signed({1'b0, q_eff >> 1});

    assign in_accept = (r_state == S_IDLE) && i_in_valid;
    assign cfg_wr    = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_MODULUS);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign is_last   = r_pos >= (q_eff - MOD_W'(1));

    assign num     = NUM_W'(r_prev_val) - NUM_W'($signed({1'b0, i_sample})) + NUM_W'(half_s);
    assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    assign div_ge = r_rem >= r_dq;

    assign quo_s = $signed({2'b00, r_quo});
    assign rem_s = $signed({3'b000, r_rem[MOD_W-1:0]});

    always_comb begin
        case (r_ci)
            2'd1: begin
                off_s = -DB_W'(q_s);
                kdel  = -KW'(1);
            end
            2'd2: begin
                off_s = DB_W'(q_s);
                kdel  = KW'(1);
            end
            default: begin
                off_s = '0;
                kdel  = '0;
            end
        endcase
    end

    assign cand_x    = r_dbase + off_s;
    assign cand_d    = cand_x[DB_W-1] ? DB_W'(-cand_x) : DB_W'(cand_x);
    assign cand_k    = r_k0 + kdel;
    assign cand_kmag = cand_k[KW-1] ? KW'(-cand_k) : KW'(cand_k);
    assign best_kmag = r_best_k[KW-1] ? KW'(-r_best_k) : KW'(r_best_k);
    assign cand_val  = r_prev_val + VAL_W'(cand_x);

    assign cand_take = (r_ci == 2'd0) || (cand_d < r_best_d)
                    || ((cand_d == r_best_d) && (cand_kmag < best_kmag))
                    || ((cand_d == r_best_d) && (cand_kmag == best_kmag)
                        && (cand_k < r_best_k));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_modulus   <= MOD_RESET;
            r_prev_val  <= '0;
            r_prev_k    <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_ci        <= '0;
            r_first     <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_best_k   <= '0;
                        r_best_val <= VAL_W'({1'b0, i_sample});
                        r_neg      <= num[NUM_W-1];
                        r_rem      <= R_W'(num_mag);
                        r_dq       <= R_W'(q_eff) << (QUO_W-1);
                        r_quo      <= '0;
                        r_cnt      <= '0;
                        if (r_pos == '0) begin
                            r_first <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_first <= 1'b0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_ge) begin
                        r_rem <= r_rem - r_dq;
                    end
                    r_quo <= {r_quo[QUO_W-2:0], div_ge};
                    r_dq  <= r_dq >> 1;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(QUO_W-1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_k0    <= r_neg ? -quo_s : quo_s;
                    r_dbase <= DB_W'(half_s) - (r_neg ? -rem_s : rem_s);
                    r_ci    <= '0;
                    r_state <= S_CAND;
                end
                S_CAND: begin
                    if (cand_take) begin
                        r_best_k   <= cand_k;
                        r_best_d   <= cand_d;
                        r_best_val <= cand_val;
                    end
                    r_ci <= r_ci + 2'd1;
                    if (r_ci == 2'd2) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_lifted    <= LIFTED_W'(r_best_val);
                        r_lift      <= LIFT_W'(r_best_k);
                        r_incr      <= r_first ? '0 : INCR_W'(r_best_k - r_prev_k);
                        r_last      <= is_last;
                        if (!cfg_wr) begin
                            r_prev_val <= r_best_val;
                            r_prev_k   <= r_best_k;
                            r_pos      <= is_last ? '0 : r_pos + MOD_W'(1);
                        end
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (cfg_wr) begin
                r_modulus  <= pwdata[MOD_W-1:0];
                r_prev_val <= '0;
                r_prev_k   <= '0;
                r_pos      <= '0;
            end
        end
    end

    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_MODULUS) ? APB_DATA_W'(r_modulus) : '0;
    assign pready = 1'b1;

    assign o_in_stall     = r_state != S_IDLE;
    assign o_out_valid    = r_out_valid;
    assign o_lifted_value = r_lifted;
    assign o_lift         = r_lift;
    assign o_increment    = r_incr;
    assign o_last         = r_last;

    `MSU_ASSERT_IMPL(a_last_pos, i_clk, i_rst_n, r_out_valid, (r_last == (r_pos == '0)))
    `MSU_ASSERT_NEXT(a_div_start, i_clk, i_rst_n, (in_accept && (r_pos != '0)), (r_state == S_DIV))
    `MSU_ASSERT_NEXT(a_done_hold, i_clk, i_rst_n, ((r_state == S_DONE) && r_out_valid && i_out_stall), (r_state == S_DONE))
    `MSU_ASSERT_IMPL(a_rem_range, i_clk, i_rst_n, (r_state == S_FIX), (r_rem < R_W'(q_eff)))

endmodule

// ===== tb/sv/modular_sequence_unwrap_unit_tb.sv =====
// Testbench for modular_sequence_unwrap_unit: directed and random residue runs, checked
// beat by beat against a built-in model of the nearest-lift unwrap.
// Depends on msu_pkg and the modular_sequence_unwrap_unit RTL.
module modular_sequence_unwrap_unit_tb;
    import msu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [LIFTED_W-1:0] lifted;
        logic signed [LIFT_W-1:0]   lift;
        logic signed [INCR_W-1:0]   incr;
        logic                       last;
    } t_unwrap_result;

    logic                        i_clk;
    logic                        i_rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]       paddr = '0;
    logic [APB_DATA_W-1:0]       pwdata = '0;
    logic [APB_DATA_W-1:0]       prdata;
    logic                        pready;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [DEF_SAMPLE_BITS-1:0]  i_sample = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic signed [LIFTED_W-1:0]  o_lifted_value;
    logic signed [LIFT_W-1:0]    o_lift;
    logic signed [INCR_W-1:0]    o_increment;
    logic                        o_last;

    logic [DEF_SAMPLE_BITS-1:0] samples_to_send[$];
    t_unwrap_result             expected_unwraps[$];

    logic [MOD_W-1:0] modulus_reg;
    longint           prev_lifted;
    longint           prev_lift;
    longint           run_pos;

    int  error_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 1'b0;
    logic hold_out = 1'b0;

    modular_sequence_unwrap_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint active_modulus();
        if (modulus_reg == 0)
            return 1;
        if (modulus_reg > DEF_MAX_MODULUS)
            return DEF_MAX_MODULUS;
        return modulus_reg;
    endfunction

    function automatic void predict_unwrap(logic [DEF_SAMPLE_BITS-1:0] sample);
        longint q, s, k0, k, d, best, best_d, lifted, lift, incr;
        bit last;
        t_unwrap_result r;
        q = active_modulus();
        s = sample;
        last = run_pos >= q - 1;
        if (run_pos == 0) begin
            lift = 0;
            incr = 0;
            lifted = s;
        end else begin
            k0 = (prev_lifted - s + q / 2) / q;
            best = k0;
            best_d = magnitude(s + k0 * q - prev_lifted);
            for (int i = 0; i < 2; i++) begin
                k = (i == 0) ? k0 - 1 : k0 + 1;
                d = magnitude(s + k * q - prev_lifted);
                if (d < best_d || (d == best_d && magnitude(k) < magnitude(best)) ||
                    (d == best_d && magnitude(k) == magnitude(best) && k < best)) begin
                    best = k;
                    best_d = d;
                end
            end
            lift = best;
            incr = lift - prev_lift;
            lifted = s + lift * q;
        end
        prev_lifted = lifted;
        prev_lift = lift;
        run_pos = last ? 0 : run_pos + 1;
        r.lifted = lifted[LIFTED_W-1:0];
        r.lift = lift[LIFT_W-1:0];
        r.incr = incr[INCR_W-1:0];
        r.last = last;
        expected_unwraps.insert(expected_unwraps.size(), r);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // input side: beats come from samples_to_send, with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                predict_unwrap(i_sample);
            if (!i_in_valid || !o_in_stall) begin
                if (samples_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_sample <= samples_to_send.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: check each beat against the oldest prediction
    always @(posedge i_clk) begin
        t_unwrap_result e;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_unwraps.size() == 0) begin
                    report_mismatch("unexpected beat, lifted", o_lifted_value, 0);
                end else begin
                    e = expected_unwraps.pop_front();
                    if (o_lifted_value !== e.lifted)
                        report_mismatch("lifted_value", o_lifted_value, e.lifted);
                    if (o_lift !== e.lift)
                        report_mismatch("lift", o_lift, e.lift);
                    if (o_increment !== e.incr)
                        report_mismatch("increment", o_increment, e.incr);
                    if (o_last !== e.last)
                        report_mismatch("last", o_last, e.last);
                end
            end
            i_out_stall <= hold_out || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // long receiver hold-off
    initial begin
        forever begin
            wait (hold_req);
            @(posedge i_clk);
            hold_out <= 1'b1;
            repeat (400) @(posedge i_clk);
            hold_out <= 1'b0;
            hold_req = 1'b0;
        end
    end

    task automatic apb_access(bit wr, logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {REG_MODULUS, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_modulus(logic [MOD_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, APB_DATA_W'(value), rd);
        modulus_reg = value;
        prev_lifted = 0;
        prev_lift = 0;
        run_pos = 0;
        apb_access(1'b0, '0, rd);
        if (rd !== APB_DATA_W'(value))
            report_mismatch("modulus readback", rd, value);
    endtask

    task automatic wait_drained();
        while (samples_to_send.size() > 0 || i_in_valid || expected_unwraps.size() > 0)
            @(negedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // wrapped random walk, with some noise and jumps
    task automatic queue_samples(int n);
        longint q, walk;
        int pick;
        q = active_modulus();
        walk = $urandom_range(0, 4095);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                samples_to_send.insert(samples_to_send.size(),
                                       DEF_SAMPLE_BITS'($urandom_range(0, 4095)));
            end else begin
                if (pick < 15)
                    walk += longint'($urandom_range(0, 8 * q)) - 4 * q;
                else
                    walk += longint'($urandom_range(0, q)) - q / 2;
                samples_to_send.insert(samples_to_send.size(),
                                       DEF_SAMPLE_BITS'(((walk % q) + q) % q));
            end
        end
    endtask

    task automatic run_phase(logic [MOD_W-1:0] value, int n, int send_pct, int stall_pct,
                             bit hold);
        set_modulus(value);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        if (hold)
            hold_req = 1'b1;
        queue_samples(n);
        wait_drained();
        wait (!hold_req);
    endtask

    initial begin
        modulus_reg = MOD_RESET;
        prev_lifted = 0;
        prev_lift = 0;
        run_pos = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset modulus, extremes, ties, out-of-range registers and samples
        samples_to_send = '{0, 4095, 2048, 0, 2048, 4095, 1};
        wait_drained();
        set_modulus(0);
        samples_to_send = '{4095, 0, 7};
        wait_drained();
        set_modulus(8191);
        samples_to_send = '{0, 4095, 10};
        wait_drained();
        set_modulus(4);
        samples_to_send = '{0, 2, 0, 2, 9, 4095};
        wait_drained();
        set_modulus(2);
        samples_to_send = '{0, 1, 1, 0, 4094};
        wait_drained();

        run_phase(3, 220, 0, 0, 0);
        run_phase(16, 220, 56, 0, 0);
        run_phase(100, 250, 0, 56, 0);
        run_phase(2, 200, 56, 56, 0);
        run_phase(37, 250, 0, 0, 1);
        run_phase(1, 100, 28, 28, 0);
        run_phase(4095, 150, 0, 0, 0);
        run_phase(8191, 200, 56, 56, 0);
        run_phase(7, 200, 0, 56, 0);
        run_phase(4096, 120, 0, 0, 0);

        repeat (40) @(posedge i_clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
